[design/ppmq_pkg.sv]
// Package for the preemptive priority message queue: sizes, codes and the
// structs of the queue cells and top level; the checker uses sizes only.
// Depends on nothing.
package ppmq_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int LEN_LIMIT   = 256;

   localparam int IDX_W    = $clog2(QUEUE_DEPTH);
   localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_W    = 16;
   localparam int LEVEL_W  = 8;
   localparam int LEN_W    = 9;
   localparam int FUNC_W   = 2;
   localparam int QCOUNT_W = 4;
   localparam int BASE_W   = 16;
   localparam int RATE_W   = 10;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 1;
   localparam int PROD_W   = LEN_W + RATE_W;
   localparam int BUSY_W   = 24;

   localparam logic [BASE_W-1:0]  BASE_RESET    = BASE_W'(500);
   localparam logic [RATE_W-1:0]  RATE_RESET    = RATE_W'(150);
   localparam logic [LEVEL_W-1:0] IDLE_LEVEL    = LEVEL_W'(255);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_SAY     = 2'd0,
      FUNC_SERVICE = 2'd1,
      FUNC_TICK    = 2'd2,
      FUNC_NOP     = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BASE_MS     = 1'b0,
      REG_MS_PER_BYTE = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [LEVEL_W-1:0] level;
      logic [LEN_W-1:0]   len;
   } entry_type;

   // Running candidate handed from cell to cell during a scan.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      entry_type        best;
      entry_type        last;
   } cand_type;

   // Scan controls broadcast to every cell.
   typedef struct packed {
      logic             find_max;
      logic [CNT_W-1:0] count;
   } scan_type;

   // Write command broadcast to every cell.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      entry_type        data;
   } wr_type;

   typedef struct packed {
      logic                accepted;
      logic                replaced;
      logic                started;
      logic                preempted;
      entry_type           play;
      logic                busy_res;
      logic [QCOUNT_W-1:0] queue_count;
   } res_type;

endpackage

[design/ppmq_cell.sv]
// One slot of the message table together with its stage of the scan chain.
// Depends on ppmq_pkg.
module ppmq_cell (
   input  logic                       clock,
   input  logic [ppmq_pkg::IDX_W-1:0] cell_index,
   input  ppmq_pkg::scan_type         scan,
   input  ppmq_pkg::wr_type           wr,
   input  ppmq_pkg::cand_type         cand_in,
   output ppmq_pkg::cand_type         cand_out
);

   ppmq_pkg::entry_type entry_ff;
   ppmq_pkg::cand_type  cand_ff;
   ppmq_pkg::cand_type  cand_in_next;
   logic                live;
   logic                better;
   logic                is_last;

   always_comb begin
      live    = ppmq_pkg::CNT_W'(cell_index) < scan.count;
      is_last = ppmq_pkg::CNT_W'(cell_index) == (scan.count - ppmq_pkg::CNT_W'(1));
      if (scan.find_max) begin
         better = entry_ff.level > cand_in.best.level;
      end else begin
         better = entry_ff.level < cand_in.best.level;
      end
      cand_in_next = cand_in;
      // Strict comparison keeps the first slot among equal levels.
      if (live && (!cand_in.valid || better)) begin
         cand_in_next.valid = 1'b1;
         cand_in_next.idx   = cell_index;
         cand_in_next.best  = entry_ff;
      end
      if (is_last) begin
         cand_in_next.last = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in_next;
      if (wr.en && (wr.idx == cell_index)) begin
         entry_ff <= wr.data;
      end
   end

   assign cand_out = cand_ff;

endmodule

[design/preemptive_priority_message_queue_unit.sv]
// Top level of the preemptive priority message queue: control sequencer,
// playback timer, configuration registers and the row of table cells.
// Depends on ppmq_pkg and ppmq_cell.
//
// Usage
// The request channel (req_*) carries one item per handshake: a say item
// offers a message (tag, level, length), a service item tries to start the
// most urgent stored message, and a tick item counts the playback time down.
// Every item yields exactly one result item on the response channel (rsp_*).
// Configuration (base_ms, ms_per_byte) is to be written by the user through
// csr_we, csr_index and csr_wdata only while the block is idle; the block
// itself does not enforce this. Writes take effect at once.
// Ticks, appends, empty says, services on an empty table and the unused code
// go straight to the done state, which loads the result register. A say on a
// full table or a service scans the row of QUEUE_DEPTH cells first, then
// decides, and when a message starts it also passes the multiply state, as
// the playback time goes through a registered multiply. One item is worked
// on at a time: the next is taken only once the result is loaded and the
// block is back in idle.
// Reset empties the table, clears the playback timer, marks nothing playing
// and restores the configuration reset values; the table slots themselves
// are not cleared. A finished result sits in the output register until the
// receiver takes it, and the next item is accepted meanwhile; its own result
// then waits until that register is free.
module preemptive_priority_message_queue_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ppmq_pkg::FUNC_W-1:0]      req_func,
   input  logic [ppmq_pkg::TAG_W-1:0]       req_text_tag,
   input  logic [ppmq_pkg::LEVEL_W-1:0]     req_level,
   input  logic [ppmq_pkg::LEN_W-1:0]       req_text_len,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_accepted,
   output logic                             rsp_replaced,
   output logic                             rsp_started,
   output logic                             rsp_preempted,
   output logic [ppmq_pkg::TAG_W-1:0]       rsp_play_tag,
   output logic [ppmq_pkg::LEVEL_W-1:0]     rsp_play_prio,
   output logic [ppmq_pkg::LEN_W-1:0]       rsp_play_len,
   output logic                             rsp_busy_res,
   output logic [ppmq_pkg::QCOUNT_W-1:0]    rsp_queue_count,
   input  logic                             csr_we,
   input  logic [ppmq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ppmq_pkg::CSR_W-1:0]       csr_wdata
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type                          state_ff, state_in;
   logic [ppmq_pkg::IDX_W-1:0]         cnt_ff, cnt_in;
   ppmq_pkg::func_type                 func_ff, func_in;
   ppmq_pkg::entry_type                item_ff, item_in;
   logic [ppmq_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [ppmq_pkg::BUSY_W-1:0]        busy_ff, busy_in;
   logic [ppmq_pkg::LEVEL_W-1:0]       playing_ff, playing_in;
   logic [ppmq_pkg::BASE_W-1:0]        base_ff, base_in;
   logic [ppmq_pkg::RATE_W-1:0]        rate_ff, rate_in;
   logic [ppmq_pkg::PROD_W-1:0]        prod_ff, prod_in;
   ppmq_pkg::res_type                  res_ff, res_in;
   ppmq_pkg::res_type                  rsp_ff, rsp_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   ppmq_pkg::entry_type                req_entry;
   ppmq_pkg::scan_type                 scan;
   ppmq_pkg::wr_type                   wr;
   ppmq_pkg::cand_type                 chain [ppmq_pkg::QUEUE_DEPTH+1];
   ppmq_pkg::cand_type                 scan_end;
   logic                               accept;
   logic                               busy_now;

   // The head of the chain carries no candidate, so cell 0 always takes its
   // own slot when it is live.
   assign chain[0] = '0;
   assign scan_end = chain[ppmq_pkg::QUEUE_DEPTH];

   // Cells see the latched function and the count; both stay steady during
   // a scan, so the end of the chain has settled when the decide state reads it.
   assign scan.find_max = (func_ff == ppmq_pkg::FUNC_SERVICE);
   assign scan.count    = count_ff;

   for (genvar g = 0; g < ppmq_pkg::QUEUE_DEPTH; g++) begin : g_cell
      ppmq_cell u_cell (
         .clock      (clock),
         .cell_index (ppmq_pkg::IDX_W'(g)),
         .scan       (scan),
         .wr         (wr),
         .cand_in    (chain[g]),
         .cand_out   (chain[g+1])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign busy_now  = (busy_ff != '0);

   // Incoming message with its length saturated at the length limit.
   always_comb begin
      req_entry.tag   = req_text_tag;
      req_entry.level = req_level;
      if (req_text_len > ppmq_pkg::LEN_W'(ppmq_pkg::LEN_LIMIT)) begin
         req_entry.len = ppmq_pkg::LEN_W'(ppmq_pkg::LEN_LIMIT);
      end else begin
         req_entry.len = req_text_len;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      busy_in      = busy_ff;
      playing_in   = playing_ff;
      base_in      = base_ff;
      rate_in      = rate_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      wr           = '0;

      if (csr_we) begin
         unique case (ppmq_pkg::csr_reg_type'(csr_index))
            ppmq_pkg::REG_BASE_MS:     base_in = csr_wdata[ppmq_pkg::BASE_W-1:0];
            ppmq_pkg::REG_MS_PER_BYTE: rate_in = csr_wdata[ppmq_pkg::RATE_W-1:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               func_in  = ppmq_pkg::func_type'(req_func);
               item_in  = req_entry;
               cnt_in   = '0;
               res_in   = '0;
               state_in = ST_DONE;
               unique case (ppmq_pkg::func_type'(req_func))
                  ppmq_pkg::FUNC_SAY: begin
                     if (req_text_len != '0) begin
                        if (count_ff < ppmq_pkg::CNT_W'(ppmq_pkg::QUEUE_DEPTH)) begin
                           // Room left: append at the end of the table.
                           wr.en           = 1'b1;
                           wr.idx          = count_ff[ppmq_pkg::IDX_W-1:0];
                           wr.data         = req_entry;
                           count_in        = count_ff + ppmq_pkg::CNT_W'(1);
                           res_in.accepted = 1'b1;
                        end else begin
                           state_in = ST_SCAN;
                        end
                     end
                  end
                  ppmq_pkg::FUNC_SERVICE: begin
                     if (count_ff != '0) begin
                        state_in = ST_SCAN;
                     end
                  end
                  ppmq_pkg::FUNC_TICK: begin
                     if (busy_now) begin
                        busy_in = busy_ff - ppmq_pkg::BUSY_W'(1);
                     end
                  end
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            cnt_in = cnt_ff + ppmq_pkg::IDX_W'(1);
            if (cnt_ff == ppmq_pkg::IDX_W'(ppmq_pkg::QUEUE_DEPTH - 1)) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            state_in = ST_DONE;
            if (func_ff == ppmq_pkg::FUNC_SAY) begin
               // Full table: displace the first lowest entry if strictly lower.
               if (item_ff.level > scan_end.best.level) begin
                  wr.en           = 1'b1;
                  wr.idx          = scan_end.idx;
                  wr.data         = item_ff;
                  res_in.accepted = 1'b1;
                  res_in.replaced = 1'b1;
               end
            end else if (!busy_now || (scan_end.best.level > playing_ff)) begin
               // Start the pick and refill its slot from the last entry.
               wr.en            = 1'b1;
               wr.idx           = scan_end.idx;
               wr.data          = scan_end.last;
               count_in         = count_ff - ppmq_pkg::CNT_W'(1);
               playing_in       = scan_end.best.level;
               res_in.started   = 1'b1;
               res_in.preempted = busy_now;
               res_in.play      = scan_end.best;
               prod_in          = ppmq_pkg::PROD_W'(scan_end.best.len) *
                                  ppmq_pkg::PROD_W'(rate_ff);
               state_in         = ST_MULT;
            end
         end

         ST_MULT: begin
            busy_in  = ppmq_pkg::BUSY_W'(base_ff) + ppmq_pkg::BUSY_W'(prod_ff);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in             = res_ff;
               rsp_in.busy_res    = busy_now;
               rsp_in.queue_count = ppmq_pkg::QCOUNT_W'(count_ff);
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         busy_ff      <= '0;
         playing_ff   <= ppmq_pkg::IDLE_LEVEL;
         base_ff      <= ppmq_pkg::BASE_RESET;
         rate_ff      <= ppmq_pkg::RATE_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         busy_ff      <= busy_in;
         playing_ff   <= playing_in;
         base_ff      <= base_in;
         rate_ff      <= rate_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      item_ff <= item_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_ff.accepted;
   assign rsp_replaced    = rsp_ff.replaced;
   assign rsp_started     = rsp_ff.started;
   assign rsp_preempted   = rsp_ff.preempted;
   assign rsp_play_tag    = rsp_ff.play.tag;
   assign rsp_play_prio   = rsp_ff.play.level;
   assign rsp_play_len    = rsp_ff.play.len;
   assign rsp_busy_res    = rsp_ff.busy_res;
   assign rsp_queue_count = rsp_ff.queue_count;

endmodule

[design/ppmq_checker.sv]
// Port-level checks for the preemptive priority message queue, bound to
// the top level. Depends on ppmq_pkg and preemptive_priority_message_queue_unit.
module ppmq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_accepted,
   input logic                          rsp_replaced,
   input logic                          rsp_started,
   input logic                          rsp_preempted,
   input logic [ppmq_pkg::TAG_W-1:0]    rsp_play_tag,
   input logic [ppmq_pkg::LEVEL_W-1:0]  rsp_play_prio,
   input logic [ppmq_pkg::LEN_W-1:0]    rsp_play_len,
   input logic [ppmq_pkg::QCOUNT_W-1:0] rsp_queue_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_queue_count <= ppmq_pkg::QCOUNT_W'(ppmq_pkg::QUEUE_DEPTH))
      else $error("queue count beyond table depth");

   a_replace_implies_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replaced |-> rsp_accepted && !rsp_started)
      else $error("replacement reported without acceptance");

   a_idle_play_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_started |->
         !rsp_preempted && rsp_play_tag == '0 && rsp_play_prio == '0 &&
         rsp_play_len == '0)
      else $error("play fields set without a start");

   a_start_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_started |-> rsp_play_len != '0 && !rsp_accepted)
      else $error("started an empty message");

endmodule

bind preemptive_priority_message_queue_unit ppmq_checker u_ppmq_checker (.*);
